// ===== hdl/dsd_pkg.sv =====
package dsd_pkg;

  localparam int MAX_SUMS  = 1024;
  localparam int MAX_FACES = 256;

  localparam int SUM_AW  = $clog2(MAX_SUMS);
  localparam int USED_W  = $clog2(MAX_SUMS + 1);
  localparam int NU_W    = USED_W + 1;
  localparam int FACES_W = 9;
  localparam int CNT_W   = 64;
  localparam int PCT_W   = 7;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_ROLL   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_CERTAIN    = 3'd1,
    ST_IMPOSSIBLE = 3'd2,
    ST_CHANCE     = 3'd3,
    ST_ERROR      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RCHK,
    S_ROLL,
    S_QRY,
    S_PCT,
    S_DONE
  } state_t;

endpackage

// ===== hdl/dsd_cmd_if.sv =====
interface dsd_cmd_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic signed [31:0]   bonus;
  logic [8:0]           faces;
  logic signed [31:0]   threshold;

  modport source (output valid, command, bonus, faces, threshold, input ready);
  modport sink   (input valid, command, bonus, faces, threshold, output ready);
endinterface

// ===== hdl/dsd_res_if.sv =====
interface dsd_res_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [63:0]          ways_at_or_above;
  logic [63:0]          total_ways;
  logic [6:0]           percent;
  logic signed [31:0]   lowest_total;
  logic signed [31:0]   highest_total;

  modport source (output valid, status, ways_at_or_above, total_ways, percent,
                  lowest_total, highest_total, input ready);
  modport sink   (input valid, status, ways_at_or_above, total_ways, percent,
                  lowest_total, highest_total, output ready);
endinterface

// ===== hdl/dsd_ram.sv =====
module dsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/dsd_pct.sv =====
module dsd_pct (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dsd_pkg::CNT_W-1:0]       part,
  input  logic [dsd_pkg::CNT_W-1:0]       whole,
  output logic                            done,
  output logic [dsd_pkg::PCT_W-1:0]       quo
);

  // floor(part*100/whole): 100 steps of compare and subtract
  logic                          busy;
  logic [dsd_pkg::PCT_W-1:0]     cnt;
  logic [dsd_pkg::CNT_W-1:0]     rem;
  logic [dsd_pkg::CNT_W-1:0]     diff;
  logic [dsd_pkg::CNT_W-1:0]     step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        diff <= whole - part;
        step <= part;
        if (part >= whole) begin
          quo  <= dsd_pkg::PCT_FULL;
          done <= 1'b1;
        end else begin
          quo  <= '0;
          cnt  <= dsd_pkg::PCT_FULL;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (rem >= diff) begin
          rem <= rem - diff;
          quo <= quo + 1'b1;
        end else begin
          rem <= rem + step;
        end
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/dice_sum_distribution_unit.sv =====
// Dice sum distribution unit. Takes one command beat at a time and returns
// exactly one result beat for it. The way-count table lives in two 1024 x 64
// RAMs used ping-pong: a roll streams the current bank through a sliding
// window sum (two reads per cycle) into the other bank, then flips banks. A
// query sums the table below the threshold, one entry per cycle, then runs a
// 100-step percentage divider. After reset the init state writes entry zero
// before the first command is taken; no clearing pass is needed, since
// entries past the used count are never used. A finished result sits in an
// output register, so the next command beat is accepted while it waits to be
// taken.
module dice_sum_distribution_unit (
  input  logic      clk,
  input  logic      rst,
  dsd_cmd_if.sink   cmd,
  dsd_res_if.source res
);

  localparam int AW = dsd_pkg::SUM_AW;
  localparam int UW = dsd_pkg::USED_W;
  localparam int NW = dsd_pkg::NU_W;
  localparam int CW = dsd_pkg::CNT_W;
  localparam int FW = dsd_pkg::FACES_W;
  localparam int PW = dsd_pkg::FACES_W + dsd_pkg::CNT_W;

  dsd_pkg::state_t state, state_next;

  // architectural state
  logic [CW-1:0]  total;
  logic [31:0]    lowest;
  logic [UW-1:0]  used;
  logic           bank;

  // working registers
  logic [FW-1:0]  faces_r;
  logic [UW-1:0]  k;
  logic [UW-1:0]  lim;          // walk length: new used count or query index
  logic [CW-1:0]  acc;          // window (roll) or running sum (query)
  logic [CW-1:0]  prod_r;
  logic           p_v, p_a, p_b;
  logic [UW-1:0]  p_k;
  dsd_pkg::status_t status_r;
  logic [CW-1:0]  ways_r;
  logic [dsd_pkg::PCT_W-1:0] pct_r;

  // RAM access
  logic [CW-1:0]  rd_a0, rd_b0, rd_a1, rd_b1, rd_a, rd_b;
  logic [AW-1:0]  ra, rb, wa;
  logic [CW-1:0]  wd;
  logic           we, wbank;
  logic [NW-1:0]  kmf;

  // roll checks
  logic [PW-1:0]  prod;
  logic [NW-1:0]  nu;
  logic           roll_err;

  // query compares
  logic signed [33:0] thr_s, lo_s, hi_s;
  logic [33:0]        idx_w;

  // divider
  logic                      pct_start, pct_done;
  logic [dsd_pkg::PCT_W-1:0] pct_q;

  logic accept, issue, walk_end, out_load;
  logic [CW-1:0] win_next;

  assign cmd.ready = (state == dsd_pkg::S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_load  = (state == dsd_pkg::S_DONE) && (!res.valid || res.ready);

  assign kmf  = {1'b0, k} - NW'(faces_r);
  assign ra   = k[AW-1:0];
  assign rb   = kmf[AW-1:0];
  assign rd_a = bank ? rd_a1 : rd_a0;
  assign rd_b = bank ? rd_b1 : rd_b0;

  assign issue    = ((state == dsd_pkg::S_ROLL) || (state == dsd_pkg::S_QRY)) && (k < lim);
  assign walk_end = (k == lim) && !p_v;

  // sliding window: add the entry entering, drop the one leaving
  assign win_next = acc + (p_a ? rd_a : '0) - (p_b ? rd_b : '0);

  always_comb begin
    we    = 1'b0;
    wbank = bank;
    wa    = '0;
    wd    = '0;
    if (state == dsd_pkg::S_INIT ||
        (accept && dsd_pkg::cmd_t'(cmd.command) == dsd_pkg::CMD_CLEAR)) begin
      we = 1'b1;
      wd = CW'(1);
    end else if (state == dsd_pkg::S_ROLL && p_v) begin
      we    = 1'b1;
      wbank = ~bank;
      wa    = p_k[AW-1:0];
      wd    = win_next;
    end
  end

  dsd_ram #(.WIDTH(CW), .DEPTH(dsd_pkg::MAX_SUMS)) u_bank0 (
    .clk(clk), .we(we && !wbank), .waddr(wa), .wdata(wd),
    .raddr_a(ra), .rdata_a(rd_a0), .raddr_b(rb), .rdata_b(rd_b0)
  );

  dsd_ram #(.WIDTH(CW), .DEPTH(dsd_pkg::MAX_SUMS)) u_bank1 (
    .clk(clk), .we(we && wbank), .waddr(wa), .wdata(wd),
    .raddr_a(ra), .rdata_a(rd_a1), .raddr_b(rb), .rdata_b(rd_b1)
  );

  assign pct_start = (state == dsd_pkg::S_QRY) && walk_end;

  dsd_pct u_pct (
    .clk(clk), .rst(rst), .start(pct_start),
    .part(total - acc), .whole(total), .done(pct_done), .quo(pct_q)
  );

  // roll legality: face range, table room, 64-bit total product
  assign prod     = PW'(total) * PW'(faces_r);
  assign nu       = NW'(used) + NW'(faces_r) - NW'(1);
  assign roll_err = (faces_r == '0) || (32'(faces_r) > 32'(dsd_pkg::MAX_FACES)) ||
                    (nu > NW'(dsd_pkg::MAX_SUMS)) || (prod[PW-1:CW] != '0);

  // query bounds, exact in 34-bit signed
  assign thr_s = 34'(cmd.threshold);
  assign lo_s  = 34'($signed(lowest));
  assign hi_s  = lo_s + $signed({1'b0, 33'(used)});
  assign idx_w = 34'(thr_s - lo_s);

  always_comb begin
    state_next = state;
    case (state)
      dsd_pkg::S_INIT: state_next = dsd_pkg::S_IDLE;
      dsd_pkg::S_IDLE: begin
        if (accept) begin
          case (dsd_pkg::cmd_t'(cmd.command))
            dsd_pkg::CMD_ROLL:  state_next = dsd_pkg::S_RCHK;
            dsd_pkg::CMD_QUERY: begin
              if (thr_s <= lo_s || thr_s >= hi_s) begin
                state_next = dsd_pkg::S_DONE;
              end else begin
                state_next = dsd_pkg::S_QRY;
              end
            end
            default: state_next = dsd_pkg::S_DONE;
          endcase
        end
      end
      dsd_pkg::S_RCHK: state_next = roll_err ? dsd_pkg::S_DONE : dsd_pkg::S_ROLL;
      dsd_pkg::S_ROLL: if (walk_end) state_next = dsd_pkg::S_DONE;
      dsd_pkg::S_QRY:  if (walk_end) state_next = dsd_pkg::S_PCT;
      dsd_pkg::S_PCT:  if (pct_done) state_next = dsd_pkg::S_DONE;
      dsd_pkg::S_DONE: if (out_load) state_next = dsd_pkg::S_IDLE;
      default:         state_next = dsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsd_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= CW'(1);
      lowest <= '0;
      used   <= UW'(1);
      bank   <= 1'b0;
      p_v    <= 1'b0;
    end else begin
      p_v <= issue;
      p_k <= k;
      p_a <= k < used;
      p_b <= (k >= UW'(faces_r)) && (kmf < NW'(used));
      if (issue) begin
        k <= k + 1'b1;
      end
      if (state == dsd_pkg::S_QRY && p_v) begin
        acc <= acc + rd_a;
      end
      if (state == dsd_pkg::S_ROLL && p_v) begin
        acc <= win_next;
      end
      case (state)
        dsd_pkg::S_IDLE: begin
          if (accept) begin
            status_r <= dsd_pkg::ST_DONE;
            ways_r   <= '0;
            pct_r    <= '0;
            faces_r  <= cmd.faces;
            k        <= '0;
            acc      <= '0;
            case (dsd_pkg::cmd_t'(cmd.command))
              dsd_pkg::CMD_CLEAR: begin
                total  <= CW'(1);
                lowest <= '0;
                used   <= UW'(1);
              end
              dsd_pkg::CMD_ADJUST: lowest <= lowest + cmd.bonus;
              dsd_pkg::CMD_QUERY: begin
                if (thr_s <= lo_s) begin
                  status_r <= dsd_pkg::ST_CERTAIN;
                  ways_r   <= total;
                  pct_r    <= dsd_pkg::PCT_FULL;
                end else if (thr_s >= hi_s) begin
                  status_r <= dsd_pkg::ST_IMPOSSIBLE;
                end else begin
                  status_r <= dsd_pkg::ST_CHANCE;
                  lim      <= idx_w[UW-1:0];
                end
              end
              default: ;
            endcase
          end
        end
        dsd_pkg::S_RCHK: begin
          if (roll_err) begin
            status_r <= dsd_pkg::ST_ERROR;
          end
          lim    <= nu[UW-1:0];
          prod_r <= prod[CW-1:0];
        end
        dsd_pkg::S_ROLL: begin
          if (walk_end) begin
            used   <= lim;
            total  <= prod_r;
            lowest <= lowest + 32'd1;
            bank   <= ~bank;
          end
        end
        dsd_pkg::S_QRY: begin
          if (walk_end) begin
            ways_r <= total - acc;
          end
        end
        dsd_pkg::S_PCT: begin
          if (pct_done) begin
            pct_r <= pct_q;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid            <= 1'b1;
      res.status           <= status_r;
      res.ways_at_or_above <= ways_r;
      res.total_ways       <= total;
      res.percent          <= pct_r;
      res.lowest_total     <= lowest;
      res.highest_total    <= lowest + 32'(used) - 32'd1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    (used != '0) && (32'(used) <= 32'(dsd_pkg::MAX_SUMS)))
    else $error("used count out of range");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == dsd_pkg::S_DONE))
    else $error("result loaded outside done state");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (bank != $past(bank)) |-> $past(state == dsd_pkg::S_ROLL))
    else $error("bank flipped outside roll");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != dsd_pkg::S_IDLE))
    else $error("accepted beat left state idle");

endmodule

// ===== tb/dice_sum_distribution_unit_test.sv =====
`timescale 1ns / 100ps

module dice_sum_distribution_unit_test;

  // Watchdog limit in cycles without any beat. The slowest command is a full
  // table roll or a full table query, plus a stall on the result side.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1500;

  logic clk;
  logic rst;

  dsd_cmd_if cmd ();
  dsd_res_if res ();

  dice_sum_distribution_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .res(res.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Expected result beat.
  typedef struct {
    dsd_pkg::status_t status;
    logic [63:0] ways;
    logic [63:0] total;
    logic [6:0]  pct;
    logic [31:0] lo;
    logic [31:0] hi;
  } dice_result_t;

  // Shadow copy of the distribution state.
  logic [63:0] dist_table [dsd_pkg::MAX_SUMS];
  logic [63:0] dist_next [dsd_pkg::MAX_SUMS];
  logic [63:0] dist_total;
  logic [31:0] dist_lo;
  int unsigned dist_used;

  dice_result_t pending_results[$];
  int  mismatches;
  bit  idle_on;
  int  quiet_cycles;

  function automatic void clear_dist();
    foreach (dist_table[i]) dist_table[i] = '0;
    dist_table[0] = 64'd1;
    dist_total = 64'd1;
    dist_lo = '0;
    dist_used = 1;
  endfunction

  // Sliding window convolution with a uniform die; returns 0 on a bad face count or overflow.
  function automatic bit roll_dist(int unsigned f);
    int unsigned nu;
    logic [63:0] win;
    logic [127:0] prod;
    if (f == 0 || f > dsd_pkg::MAX_FACES) return 1'b0;
    nu = dist_used + f - 1;
    if (nu > dsd_pkg::MAX_SUMS) return 1'b0;
    prod = {64'd0, dist_total} * f;
    if (prod[127:64] != 0) return 1'b0;
    win = '0;
    for (int unsigned k = 0; k < nu; k++) begin
      if (k < dist_used) win += dist_table[k];
      if (k >= f && k - f < dist_used) win -= dist_table[k - f];
      dist_next[k] = win;
    end
    for (int unsigned k = 0; k < nu; k++) dist_table[k] = dist_next[k];
    dist_used = nu;
    dist_total = prod[63:0];
    dist_lo += 32'd1;
    return 1'b1;
  endfunction

  function automatic dice_result_t apply_command(dsd_pkg::cmd_t c, logic [31:0] b,
                                                 logic [8:0] f, logic [31:0] t);
    dice_result_t r;
    longint thr, lo;
    logic [127:0] scaled;
    int unsigned idx;
    r.status = dsd_pkg::ST_DONE;
    r.ways = '0;
    r.pct = '0;
    case (c)
      dsd_pkg::CMD_CLEAR: clear_dist();
      dsd_pkg::CMD_ADJUST: dist_lo += b;
      dsd_pkg::CMD_ROLL: begin
        if (!roll_dist(f)) r.status = dsd_pkg::ST_ERROR;
      end
      default: begin
        thr = longint'($signed(t));
        lo = longint'($signed(dist_lo));
        if (thr <= lo) begin
          r.status = dsd_pkg::ST_CERTAIN;
          r.ways = dist_total;
          r.pct = dsd_pkg::PCT_FULL;
        end else if (thr >= lo + longint'(dist_used)) begin
          r.status = dsd_pkg::ST_IMPOSSIBLE;
        end else begin
          idx = int'(thr - lo);
          r.ways = dist_total;
          for (int unsigned k = 0; k < idx; k++) r.ways -= dist_table[k];
          r.status = dsd_pkg::ST_CHANCE;
          scaled = ({64'd0, r.ways} * 128'd100) / {64'd0, dist_total};
          r.pct = scaled[6:0];
        end
      end
    endcase
    r.total = dist_total;
    r.lo = dist_lo;
    r.hi = dist_lo + dist_used - 1;
    return r;
  endfunction

  // Send one command beat; the expectation is queued at acceptance.
  task automatic send_command(dsd_pkg::cmd_t c, logic [31:0] b = '0, logic [8:0] f = '0,
                              logic [31:0] t = '0);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      cmd.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.command = c;
    cmd.bonus = b;
    cmd.faces = f;
    cmd.threshold = t;
    do @(posedge clk); while (!cmd.ready);
    pending_results.push_back(apply_command(c, b, f, t));
    @(negedge clk);
    cmd.valid = 1'b0;
  endtask

  // Result checker: every beat must match the oldest expectation.
  always @(posedge clk) begin
    dice_result_t e;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, status %0d", res.status);
      end else begin
        e = pending_results.pop_front();
        if (res.status !== e.status || res.ways_at_or_above !== e.ways ||
            res.total_ways !== e.total || res.percent !== e.pct ||
            res.lowest_total !== e.lo || res.highest_total !== e.hi) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp st=%0d ways=%0d tot=%0d pct=%0d lo=%0d hi=%0d",
                     e.status, e.ways, e.total, e.pct, $signed(e.lo), $signed(e.hi));
            $display("         got st=%0d ways=%0d tot=%0d pct=%0d lo=%0d hi=%0d",
                     res.status, res.ways_at_or_above, res.total_ways, res.percent,
                     res.lowest_total, res.highest_total);
          end
        end
      end
    end
  end

  // Result ready: random stall bursts while idling is on.
  initial begin
    int burst;
    burst = 0;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (idle_on && burst == 0 && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 10);
      if (burst > 0) begin
        res.ready = 1'b0;
        burst--;
      end else begin
        res.ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  // Watchdog: any beat on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Threshold somewhere around the current table, random outside now and then.
  function automatic logic [31:0] pick_threshold();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return dist_lo + $urandom_range(0, dist_used + 1) - 1;
  endfunction

  // Start state, then adjust at the signed extremes and across the wrap, then a roll, a query and a clear.
  task automatic test_reset_state();
    send_command(dsd_pkg::CMD_QUERY, '0, '0, 32'd0);
    send_command(dsd_pkg::CMD_QUERY, '0, '0, 32'd1);
    send_command(dsd_pkg::CMD_ADJUST, 32'h7fff_ffff);
    send_command(dsd_pkg::CMD_ADJUST, 32'd1);
    send_command(dsd_pkg::CMD_QUERY, '0, '0, 32'h8000_0000);
    send_command(dsd_pkg::CMD_ADJUST, 32'h8000_0000);
    send_command(dsd_pkg::CMD_ADJUST, 32'hffff_ffff);
    send_command(dsd_pkg::CMD_ROLL, '0, 9'd6);
    send_command(dsd_pkg::CMD_QUERY, '0, '0, 32'h7fff_ffff);
    send_command(dsd_pkg::CMD_CLEAR, 32'hffff_ffff, 9'h1ff, 32'hffff_ffff);
  endtask

  // Bad face counts, table full, product overflow.
  task automatic test_roll_errors();
    send_command(dsd_pkg::CMD_ROLL, '0, 9'd0);
    send_command(dsd_pkg::CMD_ROLL, '0, 9'd257);
    send_command(dsd_pkg::CMD_ROLL, '0, 9'h1ff);
    send_command(dsd_pkg::CMD_ROLL, '0, 9'd1);
    repeat (5) send_command(dsd_pkg::CMD_ROLL, '0, 9'd256);
    send_command(dsd_pkg::CMD_QUERY, '0, '0, 32'd600);
    send_command(dsd_pkg::CMD_CLEAR);
    repeat (65) send_command(dsd_pkg::CMD_ROLL, '0, 9'd2);
    send_command(dsd_pkg::CMD_QUERY, '0, '0, 32'd33);
    send_command(dsd_pkg::CMD_CLEAR);
  endtask

  // Well formed games: clear, a few rolls and adjusts, then queries.
  task automatic test_random_games(int games);
    int n;
    for (int g = 0; g < games; g++) begin
      send_command(dsd_pkg::CMD_CLEAR);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_command(dsd_pkg::CMD_ROLL, '0, $urandom_range(100, 256));
        end else begin
          send_command(dsd_pkg::CMD_ROLL, '0, $urandom_range(1, 12));
        end
        if ($urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 3) == 0) send_command(dsd_pkg::CMD_ADJUST, $urandom());
          else send_command(dsd_pkg::CMD_ADJUST, $urandom_range(0, 20) - 10);
        end
      end
      n = $urandom_range(2, 5);
      for (int i = 0; i < n; i++) send_command(dsd_pkg::CMD_QUERY, '0, '0, pick_threshold());
    end
  endtask

  // Fully random beats, all fields random.
  task automatic test_random_noise(int count);
    for (int i = 0; i < count; i++) begin
      send_command(dsd_pkg::cmd_t'($urandom_range(0, 3)), $urandom(), $urandom_range(0, 511),
                   $urandom_range(0, 1) ? $urandom() : pick_threshold());
    end
  endtask

  initial begin
    mismatches = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.command = dsd_pkg::CMD_CLEAR;
    cmd.bonus = '0;
    cmd.faces = '0;
    cmd.threshold = '0;
    clear_dist();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_roll_errors();
    test_random_games(47);
    test_random_noise(60);
    // back to back tail, no idling on either side
    idle_on = 1'b0;
    test_random_games(8);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dsd_pkg.sv
hdl/dsd_cmd_if.sv
hdl/dsd_res_if.sv
hdl/dsd_ram.sv
hdl/dsd_pct.sv
hdl/dice_sum_distribution_unit.sv
tb/dice_sum_distribution_unit_test.sv
